@@ rtl/sidfe_pkg.sv @@
// ----------------------------------------------------------------------------
// sidfe_pkg
// Shared types, constants and helpers of the signed integer display frame
// encoder.
// ----------------------------------------------------------------------------
package sidfe_pkg;

	localparam int NUM_DIGITS  = 5;
	localparam int DIG_IDX_W   = 3;
	localparam int VALUE_W     = 16;
	localparam int BYTE_W      = 8;
	localparam int SIZE_W      = 8;
	localparam int COORD_W     = 32;
	localparam int CFG_DATA_W  = 32;
	localparam int CFG_INDEX_W = 2;
	localparam int WEIGHT_W    = 14;
	localparam int POS_W       = 4;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_SIZE  = 2'd0,
		REG_COORD = 2'd1
	} reg_index_t;

	localparam logic [SIZE_W-1:0]  SIZE_RESET  = 8'd3;
	localparam logic [COORD_W-1:0] COORD_RESET = 32'h3035_3033;

	localparam logic [BYTE_W-1:0] FRAME_START = 8'h00;
	localparam logic [BYTE_W-1:0] FRAME_END   = 8'hFF;
	localparam logic [BYTE_W-1:0] CHAR_E      = 8'h45;
	localparam logic [BYTE_W-1:0] CHAR_N      = 8'h4E;
	localparam logic [BYTE_W-1:0] CHAR_G      = 8'h47;
	localparam logic [BYTE_W-1:0] CHAR_MINUS  = 8'h2D;
	localparam logic [BYTE_W-1:0] ASCII_ZERO  = 8'h30;
	localparam logic [BYTE_W-1:0] SIZE_OFFSET = 8'd48;

	localparam logic [POS_W-1:0] HDR_LAST = 4'd8;

	typedef struct packed {
		logic                                neg;
		logic [DIG_IDX_W-1:0]                start;
		logic [NUM_DIGITS-1:0][3:0]          digits;
	} entry_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_HDR,
		BK_SIGN,
		BK_DIGIT,
		BK_TAIL
	} bk_state_t;

	function automatic logic [WEIGHT_W-1:0] dec_weight(input logic [DIG_IDX_W-1:0] idx);
		logic [WEIGHT_W-1:0] w;
		case (idx)
			3'd0:    w = 14'd10000;
			3'd1:    w = 14'd1000;
			3'd2:    w = 14'd100;
			3'd3:    w = 14'd10;
			default: w = 14'd1;
		endcase
		return w;
	endfunction

endpackage

@@ rtl/sidfe_front.sv @@
// ----------------------------------------------------------------------------
// sidfe_front
// Takes a value, splits off sign and magnitude and extracts the five decimal
// digits, most significant first, one per cycle; the last waits for room.
// ----------------------------------------------------------------------------
module sidfe_front (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  push,
	input  logic signed [sidfe_pkg::VALUE_W-1:0]  value,
	output logic                                  full,
	output sidfe_pkg::entry_t                     entry,
	output logic                                  entry_valid,
	input  logic                                  entry_ready
);
	import sidfe_pkg::*;

	logic                          busy_q;
	logic                          started_q;
	logic [DIG_IDX_W-1:0]          idx_q;
	logic [DIG_IDX_W-1:0]          start_q;
	logic                          neg_q;
	logic [VALUE_W-1:0]            mag_q;
	logic [NUM_DIGITS-1:0][3:0]    digits_q;

	logic [WEIGHT_W-1:0]           weight;
	logic [3:0]                    quot;
	logic [17:0]                   thr;
	logic [17:0]                   prod;
	logic [VALUE_W-1:0]            rem;
	logic                          last_digit;
	logic                          step;
	logic                          take;

	always_comb begin
		weight = dec_weight(idx_q);
		quot   = 4'd0;
		thr    = 18'd0;
		for (int k = 1; k <= 9; k++) begin
			thr = 18'(k) * {4'b0, weight};
			if ({2'b0, mag_q} >= thr) begin
				quot = 4'(k);
			end
		end
		prod = {14'b0, quot} * {4'b0, weight};
		rem  = mag_q - prod[VALUE_W-1:0];
	end

	assign last_digit  = (idx_q == DIG_IDX_W'(NUM_DIGITS - 1));
	assign entry_valid = busy_q && last_digit;
	assign step        = busy_q && (!last_digit || entry_ready);
	assign full        = busy_q;
	assign take        = push && !full;

	always_comb begin
		entry.neg                     = neg_q;
		entry.start                   = started_q ? start_q : idx_q;
		entry.digits                  = digits_q;
		entry.digits[NUM_DIGITS-1]    = quot;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			started_q <= 1'b0;
			idx_q     <= '0;
		end else if (take) begin
			busy_q    <= 1'b1;
			started_q <= 1'b0;
			idx_q     <= '0;
		end else if (step) begin
			idx_q <= idx_q + 3'd1;
			if (quot != 4'd0) begin
				started_q <= 1'b1;
			end
			if (last_digit) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			neg_q <= value[VALUE_W-1];
			mag_q <= value[VALUE_W-1] ? (~$unsigned(value) + 16'd1) : $unsigned(value);
		end else if (step) begin
			digits_q[idx_q] <= quot;
			mag_q           <= rem;
			if (!started_q && quot != 4'd0) begin
				start_q <= idx_q;
			end
		end
	end

endmodule

@@ rtl/sidfe_queue.sv @@
// ----------------------------------------------------------------------------
// sidfe_queue
// Two-entry queue of converted values between the front and the back.
// ----------------------------------------------------------------------------
module sidfe_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  sidfe_pkg::entry_t in_entry,
	input  logic              in_valid,
	output logic              in_ready,
	output sidfe_pkg::entry_t out_entry,
	output logic              out_valid,
	input  logic              out_ready
);
	import sidfe_pkg::*;

	entry_t     mem [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       wr;
	logic       rd;

	assign in_ready  = (count_q != 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign out_entry = mem[rd_ptr_q];
	assign wr        = in_valid && in_ready;
	assign rd        = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (wr) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (rd) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (wr && !rd) begin
				count_q <= count_q + 2'd1;
			end else if (rd && !wr) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			mem[wr_ptr_q] <= in_entry;
		end
	end

endmodule

@@ rtl/sidfe_back.sv @@
// ----------------------------------------------------------------------------
// sidfe_back
// Walks one queued value through the frame and hands out one byte per
// transfer through an output register.
// ----------------------------------------------------------------------------
module sidfe_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  sidfe_pkg::entry_t               entry,
	input  logic                            entry_valid,
	output logic                            entry_ready,
	input  logic [sidfe_pkg::SIZE_W-1:0]    size_code,
	input  logic [sidfe_pkg::COORD_W-1:0]   coord_chars,
	output logic                            empty,
	input  logic                            pop,
	output logic [sidfe_pkg::BYTE_W-1:0]    frame_byte,
	output logic                            last
);
	import sidfe_pkg::*;

	bk_state_t           state_q;
	bk_state_t           state_d;
	logic [POS_W-1:0]    cnt_q;
	logic [POS_W-1:0]    cnt_d;
	entry_t              cur_q;
	logic                out_valid_q;
	logic [BYTE_W-1:0]   byte_q;
	logic                last_q;

	logic                adv;
	logic                load;
	logic                emit;
	logic [BYTE_W-1:0]   byte_d;
	logic                last_d;

	assign adv         = !out_valid_q || pop;
	assign entry_ready = load;
	assign empty       = !out_valid_q;
	assign frame_byte  = byte_q;
	assign last        = last_q;

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		load    = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (entry_valid) begin
					load    = 1'b1;
					state_d = BK_HDR;
					cnt_d   = '0;
				end
			end
			BK_HDR: begin
				if (adv) begin
					if (cnt_q == HDR_LAST) begin
						state_d = cur_q.neg ? BK_SIGN : BK_DIGIT;
						cnt_d   = {1'b0, cur_q.start};
					end else begin
						cnt_d = cnt_q + 4'd1;
					end
				end
			end
			BK_SIGN: begin
				if (adv) begin
					state_d = BK_DIGIT;
					cnt_d   = {1'b0, cur_q.start};
				end
			end
			BK_DIGIT: begin
				if (adv) begin
					if (cnt_q[DIG_IDX_W-1:0] == DIG_IDX_W'(NUM_DIGITS - 1)) begin
						state_d = BK_TAIL;
					end else begin
						cnt_d = cnt_q + 4'd1;
					end
				end
			end
			BK_TAIL: begin
				if (adv) begin
					state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_comb begin
		emit   = 1'b0;
		byte_d = FRAME_START;
		last_d = 1'b0;
		case (state_q)
			BK_HDR: begin
				emit = 1'b1;
				case (cnt_q)
					4'd0:    byte_d = FRAME_START;
					4'd1:    byte_d = CHAR_E;
					4'd2:    byte_d = CHAR_N;
					4'd3:    byte_d = CHAR_G;
					4'd4:    byte_d = size_code + SIZE_OFFSET;
					4'd5:    byte_d = coord_chars[31:24];
					4'd6:    byte_d = coord_chars[23:16];
					4'd7:    byte_d = coord_chars[15:8];
					4'd8:    byte_d = coord_chars[7:0];
					default: byte_d = FRAME_START;
				endcase
			end
			BK_SIGN: begin
				emit   = 1'b1;
				byte_d = CHAR_MINUS;
			end
			BK_DIGIT: begin
				emit   = 1'b1;
				byte_d = ASCII_ZERO | {4'b0, cur_q.digits[cnt_q[DIG_IDX_W-1:0]]};
			end
			BK_TAIL: begin
				emit   = 1'b1;
				byte_d = FRAME_END;
				last_d = 1'b1;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (adv) begin
				out_valid_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cur_q <= entry;
		end
		if (adv && emit) begin
			byte_q <= byte_d;
			last_q <= last_d;
		end
	end

endmodule

@@ rtl/signed_int_display_frame_encoder.sv @@
// ----------------------------------------------------------------------------
// signed_int_display_frame_encoder
// Turns each signed 16-bit value into a display command frame byte stream.
// ----------------------------------------------------------------------------
// Each value pushed becomes one frame of 11 to 16 bytes: 0x00, "ENG", the
// size byte, four coordinate characters, an optional '-', the decimal digits
// without leading zeros and a closing 0xFF flagged by last. Bytes leave one
// per cycle while pop is held; the output stage goes idle between frames to
// load the next value. The digit converter accepts a value, then extracts
// the digits one per cycle, holding the last until the queue takes it; full
// is high while it works. Up to two converted values wait in a queue behind
// the byte stream, so pushes are taken while earlier frames still go out.
// Register writes reach header bytes not yet sent; the user must make them
// only while the block is idle, which the block itself does not enforce.
module signed_int_display_frame_encoder (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    push,
	output logic                                    full,
	input  logic signed [sidfe_pkg::VALUE_W-1:0]    value,
	output logic                                    empty,
	input  logic                                    pop,
	output logic [sidfe_pkg::BYTE_W-1:0]            frame_byte,
	output logic                                    last,
	input  logic                                    cfg_we,
	input  logic [sidfe_pkg::CFG_INDEX_W-1:0]       cfg_index,
	input  logic [sidfe_pkg::CFG_DATA_W-1:0]        cfg_data
);
	import sidfe_pkg::*;

	logic [SIZE_W-1:0]   size_code_q;
	logic [COORD_W-1:0]  coord_chars_q;

	entry_t              f_entry;
	logic                f_valid;
	logic                f_ready;
	entry_t              b_entry;
	logic                b_valid;
	logic                b_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_code_q   <= SIZE_RESET;
			coord_chars_q <= COORD_RESET;
		end else if (cfg_we) begin
			if (cfg_index == REG_SIZE) begin
				size_code_q <= cfg_data[SIZE_W-1:0];
			end
			if (cfg_index == REG_COORD) begin
				coord_chars_q <= cfg_data[COORD_W-1:0];
			end
		end
	end

	sidfe_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.value       (value),
		.full        (full),
		.entry       (f_entry),
		.entry_valid (f_valid),
		.entry_ready (f_ready)
	);

	sidfe_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_entry  (f_entry),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.out_entry (b_entry),
		.out_valid (b_valid),
		.out_ready (b_ready)
	);

	sidfe_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.entry       (b_entry),
		.entry_valid (b_valid),
		.entry_ready (b_ready),
		.size_code   (size_code_q),
		.coord_chars (coord_chars_q),
		.empty       (empty),
		.pop         (pop),
		.frame_byte  (frame_byte),
		.last        (last)
	);

endmodule

@@ rtl/sidfe_checker.sv @@
// ----------------------------------------------------------------------------
// sidfe_checker
// Port-level checks of the frame stream, bound to the top level.
// ----------------------------------------------------------------------------
module sidfe_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          empty,
	input  logic                          pop,
	input  logic [sidfe_pkg::BYTE_W-1:0]  frame_byte,
	input  logic                          last
);
	import sidfe_pkg::*;

	logic [4:0] pos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (pop && !empty) begin
			if (last) begin
				pos_q <= '0;
			end else if (pos_q != 5'd31) begin
				pos_q <= pos_q + 5'd1;
			end
		end
	end

	a_header: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> ((pos_q == 5'd0 && frame_byte == FRAME_START) ||
			(pos_q == 5'd1 && frame_byte == CHAR_E) ||
			(pos_q == 5'd2 && frame_byte == CHAR_N) ||
			(pos_q == 5'd3 && frame_byte == CHAR_G) ||
			pos_q > 5'd3))
		else $error("frame header bytes out of order");

	a_close: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && last) |-> (frame_byte == FRAME_END && pos_q >= 5'd10 && pos_q <= 5'd15))
		else $error("bad closing byte or frame length");

	a_length: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !last) |-> (pos_q < 5'd15))
		else $error("frame runs past sixteen bytes");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(frame_byte) && $stable(last)))
		else $error("stalled result changed");

endmodule

bind signed_int_display_frame_encoder sidfe_checker u_sidfe_checker (.*);
